>>> hw/rtl/twad_pkg.sv
`default_nettype none

package twad_pkg;

   // Window and channel layout
   localparam int WINDOW_DEPTH   = 10;
   localparam int SHORT_CHANNELS = 4;
   localparam int LONG_CHANNELS  = 4;
   localparam int CHANNELS       = SHORT_CHANNELS + LONG_CHANNELS;
   localparam int CH_W           = $clog2(CHANNELS);
   localparam int POS_W          = $clog2(WINDOW_DEPTH);
   localparam int SLOTS          = CHANNELS * WINDOW_DEPTH;
   localparam int ADDR_W         = $clog2(SLOTS);

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int SCALE_W     = 5;
   localparam int PERCENT_W   = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int PERCENT_BASE = 100;

   // Running sum and rounded mean by reciprocal multiply (exact for SUM_W-bit sums)
   localparam int SUM_MAX    = WINDOW_DEPTH * ((1 << SAMPLE_W) - 1);
   localparam int SUM_HALF   = WINDOW_DEPTH / 2;
   localparam int SUM_W      = $clog2(SUM_MAX + SUM_HALF + 1);
   localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
   localparam longint unsigned MEAN_RECIP =
      ((longint'(1) << MEAN_SHIFT) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);
   localparam int RECIP_W    = $clog2(MEAN_RECIP + 1);
   localparam int PROD_W     = SUM_W + RECIP_W;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Register reset values
   localparam logic [SCALE_W-1:0]   SHORT_SCALE_RESET   = 5'd1;
   localparam logic [SAMPLE_W-1:0]  SHORT_LIMIT_RESET   = 16'hFFFF;
   localparam logic [SAMPLE_W-1:0]  LONG_LIMIT_RESET    = 16'hFFFF;
   localparam logic [PERCENT_W-1:0] DIFF_PERCENT_RESET  = 7'd10;
   localparam logic [SAMPLE_W-1:0]  DIFF_ABSOLUTE_RESET = 16'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHORT_SCALE   = 3'd0,
      CSR_SHORT_LIMIT   = 3'd1,
      CSR_LONG_LIMIT    = 3'd2,
      CSR_DIFF_PERCENT  = 3'd3,
      CSR_DIFF_ABSOLUTE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                far_left;
      logic                far_right;
      logic                centre_right;
      logic                centre_left;
      logic                any_detected;
      logic [SAMPLE_W-1:0] channel_mean;
   } result_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
   } fifo_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/twad_ram.sv
`default_nettype none

module twad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 80
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hw/rtl/twad_out_fifo.sv
`default_nettype none

module twad_out_fifo (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire twad_pkg::result_type         push_data,
   input  wire logic                         pop,
   output logic                              head_valid,
   output twad_pkg::result_type              head_data,
   output twad_pkg::fifo_status_type         status
);

   twad_pkg::result_type                  entry_ff [twad_pkg::FIFO_DEPTH];
   logic [twad_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [twad_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [twad_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;
   logic                                  do_pop;

   assign head_valid   = (count_ff != '0);
   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign do_pop       = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/tof_window_average_detector.sv
// A sample passes pipeline stages 1 to 4 and the result queue before its result shows on rsp_valid.
// Throughput: one sample per cycle; samples stall only when the results queued plus
// those in pipeline stages 1 to 4 reach eight, i.e. when rsp_stall holds back results.
// Reset: synchronous, active high. Windows, sums, write positions and means clear at
// once (per-slot valid bits stand in for the window memory), registers take defaults.
`default_nettype none

module tof_window_average_detector (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // sample channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [twad_pkg::CH_W-1:0]          req_channel,
   input  wire logic [twad_pkg::SAMPLE_W-1:0]      req_sample,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_far_left,
   output logic                                    rsp_far_right,
   output logic                                    rsp_centre_right,
   output logic                                    rsp_centre_left,
   output logic                                    rsp_any_detected,
   output logic [twad_pkg::SAMPLE_W-1:0]           rsp_channel_mean,
   // register write port
   input  wire logic                               csr_wr_en,
   input  wire logic [twad_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [twad_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [twad_pkg::SCALE_W-1:0]   short_scale_ff;
   logic [twad_pkg::SAMPLE_W-1:0]  short_limit_ff;
   logic [twad_pkg::SAMPLE_W-1:0]  long_limit_ff;
   logic [twad_pkg::PERCENT_W-1:0] diff_percent_ff;
   logic [twad_pkg::SAMPLE_W-1:0]  diff_absolute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_scale_ff   <= twad_pkg::SHORT_SCALE_RESET;
         short_limit_ff   <= twad_pkg::SHORT_LIMIT_RESET;
         long_limit_ff    <= twad_pkg::LONG_LIMIT_RESET;
         diff_percent_ff  <= twad_pkg::DIFF_PERCENT_RESET;
         diff_absolute_ff <= twad_pkg::DIFF_ABSOLUTE_RESET;
      end else if (csr_wr_en) begin
         // mask each write to its register width; unknown indexes are dropped
         case (csr_index)
            twad_pkg::CSR_SHORT_SCALE:   short_scale_ff   <= csr_wdata[twad_pkg::SCALE_W-1:0];
            twad_pkg::CSR_SHORT_LIMIT:   short_limit_ff   <= csr_wdata;
            twad_pkg::CSR_LONG_LIMIT:    long_limit_ff    <= csr_wdata;
            twad_pkg::CSR_DIFF_PERCENT:  diff_percent_ff  <= csr_wdata[twad_pkg::PERCENT_W-1:0];
            twad_pkg::CSR_DIFF_ABSOLUTE: diff_absolute_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control: every stage advances each cycle. Admit a sample only
   // when the result queue can absorb everything already in flight.
   // ------------------------------------------------------------------
   logic                                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   twad_pkg::fifo_status_type           fifo_status;
   logic [twad_pkg::FIFO_CNT_W:0]       occupancy;
   logic                                accept;

   assign occupancy = (twad_pkg::FIFO_CNT_W+1)'(fifo_status.count)
                    + (twad_pkg::FIFO_CNT_W+1)'(s1_valid_ff)
                    + (twad_pkg::FIFO_CNT_W+1)'(s2_valid_ff)
                    + (twad_pkg::FIFO_CNT_W+1)'(s3_valid_ff)
                    + (twad_pkg::FIFO_CNT_W+1)'(s4_valid_ff);
   assign req_stall = (occupancy >= (twad_pkg::FIFO_CNT_W+1)'(twad_pkg::FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Stage 0: scale short range samples, pick the window slot, issue the
   // read of the slot's old value and advance the write position.
   // ------------------------------------------------------------------
   logic [twad_pkg::POS_W-1:0]    pos_ff [twad_pkg::CHANNELS];
   logic [twad_pkg::POS_W-1:0]    pos_cur, pos_in;
   logic [twad_pkg::SAMPLE_W+twad_pkg::SCALE_W-1:0] scaled_full;
   logic                          is_short;
   logic [twad_pkg::SAMPLE_W-1:0] val_in;
   logic [twad_pkg::ADDR_W-1:0]   slot_in;

   assign pos_cur     = pos_ff[req_channel];
   assign pos_in      = (pos_cur == twad_pkg::POS_W'(twad_pkg::WINDOW_DEPTH - 1))
                      ? '0 : pos_cur + 1'b1;
   assign is_short    = (req_channel < twad_pkg::CH_W'(twad_pkg::SHORT_CHANNELS));
   assign scaled_full = (twad_pkg::SAMPLE_W+twad_pkg::SCALE_W)'(req_sample)
                      * (twad_pkg::SAMPLE_W+twad_pkg::SCALE_W)'(short_scale_ff);
   // keep only the low 16 bits of the scaled product
   assign val_in      = is_short ? scaled_full[twad_pkg::SAMPLE_W-1:0] : req_sample;
   assign slot_in     = twad_pkg::ADDR_W'(req_channel) * twad_pkg::ADDR_W'(twad_pkg::WINDOW_DEPTH)
                      + twad_pkg::ADDR_W'(pos_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < twad_pkg::CHANNELS; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (accept) begin
         pos_ff[req_channel] <= pos_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: old slot value arrives from the window memory. Update the
   // running sum and overwrite the slot. Slots never written read as zero.
   // ------------------------------------------------------------------
   logic [twad_pkg::CH_W-1:0]     s1_ch_ff;
   logic [twad_pkg::SAMPLE_W-1:0] s1_val_ff;
   logic [twad_pkg::ADDR_W-1:0]   s1_slot_ff;
   logic                          s1_written_ff;
   logic [twad_pkg::SLOTS-1:0]    written_ff;
   logic [twad_pkg::SAMPLE_W-1:0] ram_rd_data;
   logic [twad_pkg::SAMPLE_W-1:0] old_val;
   logic [twad_pkg::SUM_W-1:0]    sum_ff [twad_pkg::CHANNELS];
   logic [twad_pkg::SUM_W-1:0]    sum_in;

   twad_ram #(
      .WIDTH (twad_pkg::SAMPLE_W),
      .DEPTH (twad_pkg::SLOTS)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_val_ff),
      .rd_addr (slot_in),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_ch_ff      <= req_channel;
      s1_val_ff     <= val_in;
      s1_slot_ff    <= slot_in;
      s1_written_ff <= written_ff[slot_in];
   end

   assign old_val = s1_written_ff ? ram_rd_data : '0;
   assign sum_in  = sum_ff[s1_ch_ff] - twad_pkg::SUM_W'(old_val) + twad_pkg::SUM_W'(s1_val_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         for (int i = 0; i < twad_pkg::CHANNELS; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         written_ff[s1_slot_ff] <= 1'b1;
         sum_ff[s1_ch_ff]       <= sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: rounded mean by multiply with the reciprocal of the depth.
   // ------------------------------------------------------------------
   logic [twad_pkg::CH_W-1:0]     s2_ch_ff;
   logic [twad_pkg::SUM_W-1:0]    s2_biased_ff;
   logic [twad_pkg::PROD_W-1:0]   mean_prod;
   logic [twad_pkg::SAMPLE_W-1:0] mean_in;
   logic [twad_pkg::SAMPLE_W-1:0] mean_ff [twad_pkg::CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ch_ff     <= s1_ch_ff;
      // add half the depth so the truncating divide rounds half up
      s2_biased_ff <= sum_in + twad_pkg::SUM_W'(twad_pkg::SUM_HALF);
   end

   assign mean_prod = twad_pkg::PROD_W'(s2_biased_ff) * twad_pkg::PROD_W'(twad_pkg::MEAN_RECIP);
   assign mean_in   = mean_prod[twad_pkg::MEAN_SHIFT +: twad_pkg::SAMPLE_W];

   // Unclamped means are kept so a later limit write applies to all channels.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < twad_pkg::CHANNELS; i++) begin
            mean_ff[i] <= '0;
         end
      end else if (s2_valid_ff) begin
         mean_ff[s2_ch_ff] <= mean_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: clamp every channel mean to its range limit and snapshot.
   // ------------------------------------------------------------------
   logic [twad_pkg::CH_W-1:0]     s3_ch_ff;
   logic [twad_pkg::SAMPLE_W-1:0] clamp_in [twad_pkg::CHANNELS];
   logic [twad_pkg::SAMPLE_W-1:0] clamp_ff [twad_pkg::CHANNELS];
   logic [twad_pkg::CH_W-1:0]     s4_ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_ch_ff <= s2_ch_ff;
   end

   always_comb begin
      for (int i = 0; i < twad_pkg::CHANNELS; i++) begin
         if (i < twad_pkg::SHORT_CHANNELS) begin
            clamp_in[i] = (mean_ff[i] > short_limit_ff) ? short_limit_ff : mean_ff[i];
         end else begin
            clamp_in[i] = (mean_ff[i] > long_limit_ff) ? long_limit_ff : mean_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_ch_ff <= s3_ch_ff;
      for (int i = 0; i < twad_pkg::CHANNELS; i++) begin
         clamp_ff[i] <= clamp_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: pair tests on the clamped snapshot, push into result queue.
   // ------------------------------------------------------------------
   function automatic logic percent_hit(input logic [15:0] top, input logic [15:0] bottom,
                                        input logic [6:0] pct);
      logic signed [16:0] diff;
      logic signed [24:0] lhs;
      logic        [22:0] prod;
      logic signed [24:0] rhs;
      diff = $signed({1'b0, top}) - $signed({1'b0, bottom});
      lhs  = 25'(diff) * 25'sd100;
      prod = 23'(top) * 23'(pct);
      rhs  = $signed({2'b00, prod});
      return lhs > rhs;
   endfunction

   function automatic logic absolute_hit(input logic [15:0] top, input logic [15:0] bottom,
                                         input logic [15:0] limit);
      logic signed [16:0] diff;
      diff = $signed({1'b0, top}) - $signed({1'b0, bottom});
      return diff > $signed({1'b0, limit});
   endfunction

   twad_pkg::result_type push_data;
   twad_pkg::result_type head_data;

   always_comb begin
      push_data.far_left     = percent_hit(clamp_ff[2], clamp_ff[3], diff_percent_ff);
      push_data.far_right    = percent_hit(clamp_ff[0], clamp_ff[1], diff_percent_ff);
      push_data.centre_right = absolute_hit(clamp_ff[6], clamp_ff[7], diff_absolute_ff);
      push_data.centre_left  = absolute_hit(clamp_ff[4], clamp_ff[5], diff_absolute_ff);
      push_data.any_detected = push_data.far_left || push_data.far_right
                            || push_data.centre_right || push_data.centre_left;
      push_data.channel_mean = clamp_ff[s4_ch_ff];
   end

   // Result queue decouples the pipeline from rsp_stall.
   twad_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s4_valid_ff),
      .push_data  (push_data),
      .pop        (!rsp_stall),
      .head_valid (rsp_valid),
      .head_data  (head_data),
      .status     (fifo_status)
   );

   assign rsp_far_left     = head_data.far_left;
   assign rsp_far_right    = head_data.far_right;
   assign rsp_centre_right = head_data.centre_right;
   assign rsp_centre_left  = head_data.centre_left;
   assign rsp_any_detected = head_data.any_detected;
   assign rsp_channel_mean = head_data.channel_mean;

`ifndef ASSERT_OFF
   // Accepted sample enters the pipeline on the next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted sample missing from stage 1");

   // Queue plus in-flight items never exceed queue capacity
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      occupancy <= (twad_pkg::FIFO_CNT_W+1)'(twad_pkg::FIFO_DEPTH))
      else $error("result queue overcommitted");

   // Running sum stays within the window's maximum
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_biased_ff
                       <= twad_pkg::SUM_W'(twad_pkg::SUM_MAX + twad_pkg::SUM_HALF)))
      else $error("running sum out of range");

   // Slot address stays inside the window memory
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_slot_ff < twad_pkg::ADDR_W'(twad_pkg::SLOTS)))
      else $error("window slot out of range");

   // A finished result is offered on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |=> rsp_valid)
      else $error("pushed result not visible");
`endif

endmodule

`default_nettype wire

>>> tb/tof_window_average_detector_test.sv
module tof_window_average_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   import twad_pkg::*;

   // Sender and receiver idling modes, cycled through the random phases
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One line of the directed table: either a sample transfer or a register write
   typedef struct packed {
      logic                   is_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [CH_W-1:0]        channel;
      logic [CSR_DATA_W-1:0]  value;
      logic                   typed;
      result_type             result;
   } probe_row_type;

   localparam logic ROW_SAMPLE = 1'b0;
   localparam logic ROW_WRITE  = 1'b1;
   localparam logic TYPED      = 1'b1;
   localparam logic PREDICT    = 1'b0;

   localparam result_type NO_DETECT = '0;

   // Indexes past the register list; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = CSR_DIFF_ABSOLUTE + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX   = '1;
   localparam int CSR_COUNT = int'(CSR_DIFF_ABSOLUTE) + 1;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 228;

   // Directed table. Expected results are typed in for the first rows after reset
   // (zeroed windows, full-scale samples, the long pair just over its threshold);
   // the rest go through the predictor.
   localparam int DIRECTED_ROWS = 28;
   localparam probe_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, '0, 3'd0, 16'd0,     TYPED, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0}},
      '{ROW_SAMPLE, '0, 3'd0, 16'hFFFF,  TYPED, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 16'd6554}},
      '{ROW_SAMPLE, '0, 3'd1, 16'hFFFF,  TYPED, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd6554}},
      '{ROW_SAMPLE, '0, 3'd5, 16'hFFFF,  TYPED, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd6554}},
      '{ROW_SAMPLE, '0, 3'd4, 16'hFFFF,  TYPED, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd6554}},
      '{ROW_SAMPLE, '0, 3'd7, 16'd1000,  TYPED, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd100}},
      '{ROW_SAMPLE, '0, 3'd6, 16'd2010,  TYPED, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'd201}},
      // rounding half up, then just below half
      '{ROW_SAMPLE, '0, 3'd3, 16'd5,     PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd3, 16'd4,     PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd2, 16'd4,     PREDICT, NO_DETECT},
      // scale write masked to five bits, product cut to 16 bits
      '{ROW_WRITE,  CSR_SHORT_SCALE, 3'd0, 16'hFFE3, PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd2, 16'd30000, PREDICT, NO_DETECT},
      // zero scale stores zeros
      '{ROW_WRITE,  CSR_SHORT_SCALE, 3'd0, 16'd0,    PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd1, 16'd12345, PREDICT, NO_DETECT},
      // percentage above one hundred
      '{ROW_WRITE,  CSR_DIFF_PERCENT, 3'd0, 16'h007F, PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd0, 16'd40000, PREDICT, NO_DETECT},
      // clamp every short mean to zero
      '{ROW_WRITE,  CSR_SHORT_LIMIT, 3'd0, 16'd0,    PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd2, 16'd7,     PREDICT, NO_DETECT},
      // writes past the register list are dropped
      '{ROW_WRITE,  CSR_SPARE_INDEX, 3'd0, 16'hFFFF, PREDICT, NO_DETECT},
      '{ROW_WRITE,  CSR_TOP_INDEX,   3'd0, 16'hFFFF, PREDICT, NO_DETECT},
      '{ROW_WRITE,  CSR_LONG_LIMIT,  3'd0, 16'd150,  PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd6, 16'hFFFF,  PREDICT, NO_DETECT},
      '{ROW_WRITE,  CSR_DIFF_ABSOLUTE, 3'd0, 16'd0,  PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd7, 16'd0,     PREDICT, NO_DETECT},
      '{ROW_WRITE,  CSR_DIFF_ABSOLUTE, 3'd0, 16'hFFFF, PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd4, 16'd0,     PREDICT, NO_DETECT},
      '{ROW_WRITE,  CSR_DIFF_PERCENT, 3'd0, 16'd0,   PREDICT, NO_DETECT},
      '{ROW_SAMPLE, '0, 3'd3, 16'hFFFF,  PREDICT, NO_DETECT}
   };

   // Register settings per random phase, in register index order.
   // The last two rows are filled in at run time.
   logic [CSR_DATA_W-1:0] phase_settings [RANDOM_PHASES][CSR_COUNT] = '{
      '{16'd1,  16'hFFFF,  16'hFFFF,  16'd10,  16'd100},
      '{16'd16, 16'hFFFF,  16'hFFFF,  16'd100, 16'd0},
      '{16'd31, 16'd30000, 16'd20000, 16'd0,   16'hFFFF},
      '{16'd0,  16'd0,     16'd400,   16'd127, 16'd50},
      '{16'd3,  16'd5000,  16'hFFFF,  16'd25,  16'd1000},
      '{16'd17, 16'hFFFF,  16'd8000,  16'd50,  16'd10},
      '{default: 16'd0},
      '{default: 16'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [CH_W-1:0]        req_channel = '0;
   logic [SAMPLE_W-1:0]    req_sample  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic                   rsp_far_left;
   logic                   rsp_far_right;
   logic                   rsp_centre_right;
   logic                   rsp_centre_left;
   logic                   rsp_any_detected;
   logic [SAMPLE_W-1:0]    rsp_channel_mean;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   // Predictor copy of the windows and the registers
   logic [SAMPLE_W-1:0]  window_mem [CHANNELS][WINDOW_DEPTH];
   int unsigned          window_total [CHANNELS];
   int unsigned          next_slot [CHANNELS];
   logic [SCALE_W-1:0]   cfg_scale;
   logic [SAMPLE_W-1:0]  cfg_short_limit;
   logic [SAMPLE_W-1:0]  cfg_long_limit;
   logic [PERCENT_W-1:0] cfg_percent;
   logic [SAMPLE_W-1:0]  cfg_absolute;

   // Detector results still owed by the block, oldest first
   result_type pending_detections [$];
   result_type oldest_detection;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatches         = 0;

   tof_window_average_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_far_left     (rsp_far_left),
      .rsp_far_right    (rsp_far_right),
      .rsp_centre_right (rsp_centre_right),
      .rsp_centre_left  (rsp_centre_left),
      .rsp_any_detected (rsp_any_detected),
      .rsp_channel_mean (rsp_channel_mean),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // Rounded window mean, clamped to the ceiling of its range
   function automatic logic [SAMPLE_W-1:0] mean_of(input int ch);
      int unsigned avg;
      int unsigned ceiling;
      avg = (window_total[ch] + WINDOW_DEPTH / 2) / WINDOW_DEPTH;
      ceiling = (ch < SHORT_CHANNELS) ? cfg_short_limit : cfg_long_limit;
      if (avg > ceiling) begin
         avg = ceiling;
      end
      return SAMPLE_W'(avg);
   endfunction

   // Short pairs: difference times one hundred against top times the percentage
   function automatic logic percent_exceeds(input logic [SAMPLE_W-1:0] top,
                                            input logic [SAMPLE_W-1:0] bottom);
      longint gap;
      gap = longint'(top) - longint'(bottom);
      return gap * PERCENT_BASE > longint'(top) * longint'(cfg_percent);
   endfunction

   // Long pairs: plain difference against the absolute threshold
   function automatic logic absolute_exceeds(input logic [SAMPLE_W-1:0] top,
                                             input logic [SAMPLE_W-1:0] bottom);
      longint gap;
      gap = longint'(top) - longint'(bottom);
      return gap > longint'(cfg_absolute);
   endfunction

   // Push one sample into its window and work out the detector outputs
   function automatic result_type advance_window(input int ch,
                                                 input logic [SAMPLE_W-1:0] raw);
      int unsigned product;
      logic [SAMPLE_W-1:0] stored;
      int slot;
      result_type r;
      stored = raw;
      if (ch < SHORT_CHANNELS) begin
         product = raw * cfg_scale;
         stored = SAMPLE_W'(product);
      end
      slot = next_slot[ch];
      window_total[ch] = window_total[ch] - window_mem[ch][slot] + stored;
      window_mem[ch][slot] = stored;
      next_slot[ch] = (slot + 1) % WINDOW_DEPTH;
      // pairs are (top, bottom): (2,3), (0,1), (6,7), (4,5)
      r.far_left     = percent_exceeds(mean_of(2), mean_of(3));
      r.far_right    = percent_exceeds(mean_of(0), mean_of(1));
      r.centre_right = absolute_exceeds(mean_of(6), mean_of(7));
      r.centre_left  = absolute_exceeds(mean_of(4), mean_of(5));
      r.any_detected = r.far_left | r.far_right | r.centre_right | r.centre_left;
      r.channel_mean = mean_of(ch);
      return r;
   endfunction

   // Full-range values most often, with short ranges, the extremes and a cluster
   // around a per-phase level so that pair tests land near their thresholds
   function automatic logic [SAMPLE_W-1:0] random_sample(input logic [SAMPLE_W-1:0] level);
      case ($urandom_range(9))
         0, 1, 2, 3: return SAMPLE_W'($urandom);
         4, 5:       return SAMPLE_W'($urandom_range(2000));
         6:          return $urandom_range(1) ? '1 : '0;
         default:    return SAMPLE_W'(level + $urandom_range(255) - 128);
      endcase
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 84;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 84;
         end
         default: begin
            sender_idle_pct = 28;
            receiver_stall_pct = 28;
         end
      endcase
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_detections.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write one register; the caller guarantees the block is idle.
   // The enable is lowered by the next sample transfer.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SHORT_SCALE:   cfg_scale       = data[SCALE_W-1:0];
         CSR_SHORT_LIMIT:   cfg_short_limit = data[SAMPLE_W-1:0];
         CSR_LONG_LIMIT:    cfg_long_limit  = data[SAMPLE_W-1:0];
         CSR_DIFF_PERCENT:  cfg_percent     = data[PERCENT_W-1:0];
         CSR_DIFF_ABSOLUTE: cfg_absolute    = data[SAMPLE_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one sample, hold it until the transfer, then log what it must produce.
   // Valid stays high on return so back-to-back samples keep streaming.
   task automatic push_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] raw,
                              input logic typed, input result_type typed_result);
      result_type predicted;
      csr_wr_en <= 1'b0;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= raw;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = advance_window(int'(ch), raw);
      pending_detections.push_back(typed ? typed_result : predicted);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Receiver back-pressure, never tied to rsp_valid
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Check every result transfer against the oldest owed result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_detections.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual mean %0d",
                     $time, rsp_channel_mean);
         end else begin
            oldest_detection = pending_detections.pop_front();
            compare_field("far_left", oldest_detection.far_left, rsp_far_left);
            compare_field("far_right", oldest_detection.far_right, rsp_far_right);
            compare_field("centre_right", oldest_detection.centre_right, rsp_centre_right);
            compare_field("centre_left", oldest_detection.centre_left, rsp_centre_left);
            compare_field("any_detected", oldest_detection.any_detected, rsp_any_detected);
            compare_field("channel_mean", oldest_detection.channel_mean, rsp_channel_mean);
         end
      end
   end

   // Stimulus: reset, directed table, then random phases over several settings
   initial begin
      probe_row_type row;
      logic [SAMPLE_W-1:0] sample_level;

      // Mirror the reset state: empty windows, default registers
      for (int ch = 0; ch < CHANNELS; ch++) begin
         window_total[ch] = 0;
         next_slot[ch] = 0;
         for (int s = 0; s < WINDOW_DEPTH; s++) begin
            window_mem[ch][s] = '0;
         end
      end
      cfg_scale       = SHORT_SCALE_RESET;
      cfg_short_limit = SHORT_LIMIT_RESET;
      cfg_long_limit  = LONG_LIMIT_RESET;
      cfg_percent     = DIFF_PERCENT_RESET;
      cfg_absolute    = DIFF_ABSOLUTE_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; drain before each register write
      set_idling(IDLE_NONE);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (row.is_write) begin
            wait_for_results();
            write_register(row.index, row.value);
         end else begin
            push_sample(row.channel, row.value, row.typed, row.result);
         end
      end

      // One in-range random setting and one with raw 16-bit data to exercise masking
      phase_settings[6][CSR_SHORT_SCALE]   = CSR_DATA_W'($urandom_range(16, 1));
      phase_settings[6][CSR_SHORT_LIMIT]   = CSR_DATA_W'($urandom);
      phase_settings[6][CSR_LONG_LIMIT]    = CSR_DATA_W'($urandom);
      phase_settings[6][CSR_DIFF_PERCENT]  = CSR_DATA_W'($urandom_range(100));
      phase_settings[6][CSR_DIFF_ABSOLUTE] = CSR_DATA_W'($urandom_range(4000));
      for (int r = 0; r < CSR_COUNT; r++) begin
         phase_settings[7][r] = CSR_DATA_W'($urandom);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_results();
         for (int r = 0; r < CSR_COUNT; r++) begin
            write_register(CSR_INDEX_W'(r), phase_settings[p][r]);
         end
         set_idling(idle_mode_type'(p % 4));
         sample_level = SAMPLE_W'($urandom);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off the sender once until the block has emptied out
            if (p == 2 && i == PHASE_ITEMS / 2) begin
               wait_for_results();
            end
            push_sample(CH_W'($urandom_range(CHANNELS - 1)), random_sample(sample_level),
                        PREDICT, NO_DETECT);
         end
      end

      // Drain, then leave room for any stray result to show up
      wait_for_results();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("tof_window_average_detector_test: PASS");
      end else begin
         $display("tof_window_average_detector_test: FAIL");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #2ms;
      $display("tof_window_average_detector_test: FAIL");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/twad_pkg.sv
hw/rtl/twad_ram.sv
hw/rtl/twad_out_fifo.sv
hw/rtl/tof_window_average_detector.sv
tb/tof_window_average_detector_test.sv
